### design/gregorian_date_calculator_top_defines.svh
// Assertion macros shared by the date calculator RTL.
`ifndef GREGORIAN_DATE_CALCULATOR_TOP_DEFINES_SVH
`define GREGORIAN_DATE_CALCULATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GDC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define GDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdc: next-cycle check failed");

`endif

### design/gdc_pkg.sv
// Types, constants and table functions of the Gregorian date calculator.
package gdc_pkg;

    // Year bias that keeps the day count positive; a whole number of 400-year cycles
    // minus one, so that the count of years before a date is year + YEAR_BIAS.
    localparam int unsigned YEAR_BIAS = 399;
    localparam int unsigned P_W       = 15;
    localparam int unsigned Q100_W    = 8;
    localparam int unsigned Q400_W    = 6;
    localparam int unsigned SER_W     = 23;
    localparam int unsigned DIST_W    = 22;
    localparam int unsigned DOY_W     = 9;

    // Reciprocal divide by 100: exact for operands below 43690.
    localparam int unsigned DIV100_SH  = 19;
    localparam int unsigned DIV100_MW  = 13;
    localparam logic [DIV100_MW-1:0] DIV100_MUL = 13'd5243;
    localparam int unsigned PROD100_W  = P_W + DIV100_MW;

    // Reciprocal divide by 7: exact for operands below 22369621.
    localparam int unsigned DIV7_SH  = 26;
    localparam int unsigned DIV7_MW  = 24;
    localparam logic [DIV7_MW-1:0] DIV7_MUL = 24'd9586981;
    localparam int unsigned PROD7_W  = SER_W + DIV7_MW;
    localparam int unsigned Q7_W     = 21;

    localparam int unsigned CENTURY    = 100;
    localparam int unsigned QUAD_CENT  = 400;
    localparam int unsigned YEAR_DAYS  = 365;
    localparam int unsigned WEEK_DAYS  = 7;
    localparam int unsigned MONTHS     = 12;

    localparam logic [1:0] ORD_BEFORE = 2'd0;
    localparam logic [1:0] ORD_EQUAL  = 2'd1;
    localparam logic [1:0] ORD_AFTER  = 2'd2;

    typedef struct packed {
        logic [4:0]  d;
        logic [3:0]  m;
        logic [13:0] y;
    } date_t;

    typedef struct packed {
        logic [4:0]  day_a;
        logic [3:0]  month_a;
        logic [13:0] year_a;
        logic [4:0]  day_b;
        logic [3:0]  month_b;
        logic [13:0] year_b;
    } gdc_req_t;

    typedef struct packed {
        logic              leap_a;
        logic [DOY_W-1:0]  day_of_year_a;
        logic [2:0]        weekday_a;
        logic [4:0]        next_day_a;
        logic [3:0]        next_month_a;
        logic [13:0]       next_year_a;
        logic [1:0]        order;
        logic              same_weekday;
        logic [DIST_W-1:0] day_distance;
    } gdc_rsp_t;

    // Month codes outside 1..12 are clamped to the nearest valid month.
    function automatic logic [3:0] sat_month(input logic [3:0] m);
        logic [3:0] r;
        if (m == 4'd0) begin
            r = 4'd1;
        end else if (m > 4'(MONTHS)) begin
            r = 4'(MONTHS);
        end else begin
            r = m;
        end
        return r;
    endfunction

    // Days in the months before the given month of a common year.
    function automatic logic [DOY_W-1:0] days_before(input logic [3:0] m);
        logic [DOY_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] r;
        case (m)
            4'd2:    r = leap ? 5'd29 : 5'd28;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   r = 5'd30;
            default: r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

### design/gdc_stream_ifs.sv
// Valid/ready stream interfaces for the date pair requests and the results.
interface gdc_req_if import gdc_pkg::*; ();
    logic     valid;
    logic     ready;
    gdc_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gdc_rsp_if import gdc_pkg::*; ();
    logic     valid;
    logic     ready;
    gdc_rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/gregorian_date_calculator_top.sv
// Gregorian date calculator: five-stage pipeline from a date pair to its result beat.
//
//  Channel | Dir | Beat contents
//  --------+-----+---------------------------------------------------------------
//  req     | in  | day, month and year of the first and the second date
//  rsp     | out | leap flag, day of year, weekday and next date of the first date,
//          |     | order, same-weekday flag and day distance of the pair
//
// A request beat is accepted in every cycle unless a stall on rsp has backed up into stage 1;
// its result passes through the five register stages of the serial-day pipeline.
// Reset clears only the valid bits of the stages; the payload registers are not reset.
// Each stage advances when it is empty or when the stage after it advances, so a
// stall on rsp backs up stage by stage, bubbles are squeezed out, and nothing is lost
// or repeated.
`include "gregorian_date_calculator_top_defines.svh"

module gregorian_date_calculator_top import gdc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    gdc_req_if.sink   req,
    gdc_rsp_if.source rsp
);

    // Fields carried alongside the serial day counts once the next date is known.
    typedef struct packed {
        logic             leap;
        logic [DOY_W-1:0] doy;
        date_t            nxt;
        logic [1:0]       order;
    } side_t;

    // Stage valid bits and advance enables.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic ce1, ce2, ce3, ce4, ce5;

    // Stage 1: clamped dates, biased year count, its quotient by 100 and the order of the pair.
    date_t             in_date [2];
    logic [P_W-1:0]    p1_next [2];
    logic [PROD100_W-1:0] prod100 [2];
    logic [Q100_W-1:0] q100_1_next [2];
    logic [1:0]        order1_next;
    date_t             date1_reg [2];
    logic [P_W-1:0]    p1_reg [2];
    logic [Q100_W-1:0] q100_1_reg [2];
    logic [1:0]        order1_reg;

    // Stage 2: leap flags, day of year and the year part of the day count.
    logic [Q400_W-1:0] q400_2_next [2];
    logic [P_W-1:0]    r100 [2];
    logic [P_W-1:0]    r400 [2];
    logic              leap2_next [2];
    logic [DOY_W-1:0]  ord2_next [2];
    logic [SER_W-1:0]  base2_next [2];
    date_t             date2_reg;
    logic              leap2_reg;
    logic [DOY_W-1:0]  ord2_reg [2];
    logic [SER_W-1:0]  base2_reg [2];
    logic [Q100_W-1:0] q100_2_reg [2];
    logic [Q400_W-1:0] q400_2_reg [2];
    logic [1:0]        order2_reg;

    // Stage 3: serial day counts and the following date of the first date.
    logic [SER_W-1:0]  ser3_next [2];
    side_t             side3_next;
    logic [4:0]        mlen;
    logic [SER_W-1:0]  ser3_reg [2];
    side_t             side3_reg;

    // Stage 4: distance and the quotient of each serial count by 7.
    logic [PROD7_W-1:0] prod7 [2];
    logic [Q7_W-1:0]    q7_4_next [2];
    logic [DIST_W-1:0]  dist4_next;
    logic [SER_W-1:0]   ser4_reg [2];
    logic [Q7_W-1:0]    q7_4_reg [2];
    logic [DIST_W-1:0]  dist4_reg;
    side_t              side4_reg;

    // Stage 5: weekdays and the output register.
    logic [SER_W-1:0]  wrem [2];
    gdc_rsp_t          rsp_next;
    gdc_rsp_t          rsp_reg;

    // A stage takes new data when it is empty or its contents move on.
    assign ce5 = !v5_reg || rsp.ready;
    assign ce4 = !v4_reg || ce5;
    assign ce3 = !v3_reg || ce4;
    assign ce2 = !v2_reg || ce3;
    assign ce1 = !v1_reg || ce2;

    assign req.ready = ce1;
    assign rsp.valid = v5_reg;
    assign rsp.data  = rsp_reg;

    assign in_date[0] = '{d: req.data.day_a, m: sat_month(req.data.month_a),
                          y: req.data.year_a};
    assign in_date[1] = '{d: req.data.day_b, m: sat_month(req.data.month_b),
                          y: req.data.year_b};

    // Stage 1 logic. The comparison is lexicographic on year, month and day.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            p1_next[i]     = P_W'(in_date[i].y) + P_W'(YEAR_BIAS);
            prod100[i]     = PROD100_W'(p1_next[i]) * PROD100_W'(DIV100_MUL);
            q100_1_next[i] = Q100_W'(prod100[i] >> DIV100_SH);
        end
        if (in_date[0] == in_date[1]) begin
            order1_next = ORD_EQUAL;
        end else if ({in_date[0].y, in_date[0].m, in_date[0].d} <
                     {in_date[1].y, in_date[1].m, in_date[1].d}) begin
            order1_next = ORD_BEFORE;
        end else begin
            order1_next = ORD_AFTER;
        end
    end

    // Stage 2 logic. The leap test runs on the biased year count p = year + 399,
    // so year divisible by 4, 100 or 400 shows as p leaving 3, 99 or 399.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            q400_2_next[i] = Q400_W'(q100_1_reg[i] >> 2);
            r100[i] = p1_reg[i] - P_W'(q100_1_reg[i]) * P_W'(CENTURY);
            r400[i] = p1_reg[i] - P_W'(q400_2_next[i]) * P_W'(QUAD_CENT);
            leap2_next[i] = (r400[i] == P_W'(YEAR_BIAS % QUAD_CENT)) ||
                            ((r100[i] != P_W'(YEAR_BIAS % CENTURY)) &&
                             (p1_reg[i][1:0] == 2'(YEAR_BIAS % 4)));
            ord2_next[i] = days_before(date1_reg[i].m) + DOY_W'(date1_reg[i].d) +
                           DOY_W'((date1_reg[i].m > 4'd2) && leap2_next[i]);
            base2_next[i] = SER_W'(p1_reg[i]) * SER_W'(YEAR_DAYS) +
                            SER_W'(p1_reg[i] >> 2);
        end
    end

    // Stage 3 logic.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            ser3_next[i] = base2_reg[i] + SER_W'(ord2_reg[i]) + SER_W'(q400_2_reg[i]) -
                           SER_W'(q100_2_reg[i]);
        end
        mlen             = month_len(date2_reg.m, leap2_reg);
        side3_next.leap  = leap2_reg;
        side3_next.doy   = ord2_reg[0];
        side3_next.order = order2_reg;
        side3_next.nxt   = date2_reg;
        // Day at or past the month end rolls into the next month; day 0 steps to 1.
        if (date2_reg.d >= mlen) begin
            side3_next.nxt.d = 5'd1;
            if (date2_reg.m == 4'(MONTHS)) begin
                side3_next.nxt.m = 4'd1;
                side3_next.nxt.y = date2_reg.y + 14'd1;
            end else begin
                side3_next.nxt.m = date2_reg.m + 4'd1;
            end
        end else begin
            side3_next.nxt.d = date2_reg.d + 5'd1;
        end
    end

    // Stage 4 logic.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            prod7[i]     = PROD7_W'(ser3_reg[i]) * PROD7_W'(DIV7_MUL);
            q7_4_next[i] = Q7_W'(prod7[i] >> DIV7_SH);
        end
        if (ser3_reg[0] > ser3_reg[1]) begin
            dist4_next = DIST_W'(ser3_reg[0] - ser3_reg[1]);
        end else begin
            dist4_next = DIST_W'(ser3_reg[1] - ser3_reg[0]);
        end
    end

    // Stage 5 logic.
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            wrem[i] = ser4_reg[i] - SER_W'(q7_4_reg[i]) * SER_W'(WEEK_DAYS);
        end
        rsp_next.leap_a        = side4_reg.leap;
        rsp_next.day_of_year_a = side4_reg.doy;
        rsp_next.weekday_a     = wrem[0][2:0];
        rsp_next.next_day_a    = side4_reg.nxt.d;
        rsp_next.next_month_a  = side4_reg.nxt.m;
        rsp_next.next_year_a   = side4_reg.nxt.y;
        rsp_next.order         = side4_reg.order;
        rsp_next.same_weekday  = (wrem[0][2:0] == wrem[1][2:0]);
        rsp_next.day_distance  = dist4_reg;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (ce1) v1_reg <= req.valid;
            if (ce2) v2_reg <= v1_reg;
            if (ce3) v3_reg <= v2_reg;
            if (ce4) v4_reg <= v3_reg;
            if (ce5) v5_reg <= v4_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (ce1) begin
            date1_reg   <= in_date;
            p1_reg      <= p1_next;
            q100_1_reg  <= q100_1_next;
            order1_reg  <= order1_next;
        end
        if (ce2) begin
            date2_reg   <= date1_reg[0];
            leap2_reg   <= leap2_next[0];
            ord2_reg    <= ord2_next;
            base2_reg   <= base2_next;
            q100_2_reg  <= q100_1_reg;
            q400_2_reg  <= q400_2_next;
            order2_reg  <= order1_reg;
        end
        if (ce3) begin
            ser3_reg    <= ser3_next;
            side3_reg   <= side3_next;
        end
        if (ce4) begin
            ser4_reg    <= ser3_reg;
            q7_4_reg    <= q7_4_next;
            dist4_reg   <= dist4_next;
            side4_reg   <= side3_reg;
        end
        if (ce5) begin
            rsp_reg     <= rsp_next;
        end
    end

    // Checks.
    `GDC_ASSERT_IMPL(a_idle_ready, !rsp.valid, req.ready)
    `GDC_ASSERT_NEXT(a_accept_fills, req.valid && req.ready, v1_reg)
    `GDC_ASSERT_IMPL(a_equal_zero_dist, rsp.valid && rsp.data.order == ORD_EQUAL, rsp.data.day_distance == '0)
    `GDC_ASSERT_IMPL(a_equal_same_wday, rsp.valid && rsp.data.order == ORD_EQUAL, rsp.data.same_weekday)
    `GDC_ASSERT_IMPL(a_wday_range, rsp.valid, rsp.data.weekday_a < 3'(WEEK_DAYS))

endmodule
